// File: design/qltu_pkg.sv
// package for the q-table update engine: sizes, fixed-point widths,
// register indexes and the sequencer state type. no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qltu_pkg;

    localparam int STATES  = 256;
    localparam int ACTIONS = 8;

    // sizes follow from the table shape
    localparam int STATE_W = $clog2(STATES);
    localparam int ACT_W   = $clog2(ACTIONS);
    localparam int ADDR_W  = STATE_W + ACT_W;
    localparam int DEPTH   = STATES * ACTIONS;
    localparam int CNT_W   = ACT_W + 1;

    // item field widths
    localparam int IN_STATE_W = 8;
    localparam int IN_ACT_W   = 3;
    localparam int OUT_ACT_W  = 3;
    localparam int SCORE_W    = 32;
    localparam int DIST_W     = 24;

    // configuration port
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'b1;
    localparam logic [CFG_W-1:0] LEARN_RATE_RST = 17'd6554;
    localparam logic [CFG_W-1:0] DISCOUNT_RST   = 17'd58982;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // fixed-point datapath widths
    localparam int MUL_A_W = CFG_W + 1;
    localparam int TD_W    = 36;
    localparam int PROD_W  = MUL_A_W + TD_W;
    localparam int SUM_W   = 40;
    localparam int FRAC_W  = 16;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
    localparam logic signed [TD_W-1:0] REWARD_GOOD = TD_W'(65536);
    localparam logic signed [TD_W-1:0] REWARD_BAD  = -TD_W'(327680);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN_PRE,
        ST_RD_OLD,
        ST_OLD,
        ST_TD,
        ST_MUL,
        ST_WR,
        ST_SCAN_POST,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// File: design/qltu_item_if.sv
// input channel of the q-table update engine: valid/ready plus one command item
// depends on qltu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface qltu_item_if import qltu_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [IN_STATE_W-1:0]        state_index;
    logic [IN_ACT_W-1:0]          action_index;
    logic signed [SCORE_W-1:0]    load_value;
    logic [DIST_W-1:0]            target_distance;

    modport source (
        output valid, cmd, state_index, action_index, load_value, target_distance,
        input  ready
    );
    modport sink (
        input  valid, cmd, state_index, action_index, load_value, target_distance,
        output ready
    );
endinterface

`default_nettype wire

// File: design/qltu_result_if.sv
// output channel of the q-table update engine: valid/ready plus one result item
// depends on qltu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface qltu_result_if import qltu_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [OUT_ACT_W-1:0]         chosen_action;
    logic signed [SCORE_W-1:0]    best_score;
    logic signed [SCORE_W-1:0]    updated_score;
    logic                         reward_positive;
    logic                         update_done;

    modport source (
        output valid, chosen_action, best_score, updated_score, reward_positive,
        output update_done,
        input  ready
    );
    modport sink (
        input  valid, chosen_action, best_score, updated_score, reward_positive,
        input  update_done,
        output ready
    );
endinterface

`default_nettype wire

// File: design/q_learning_table_update.sv
// q-table update engine top level: score memory, scan/update sequencer, output register
// depends on qltu_pkg, qltu_item_if, qltu_result_if
// load: the entry is written, then the result is registered. step: with an earlier step,
// the row is scanned, the previous entry is read and updated, and the row is scanned again;
// the first step only scans the row once. the row scans go through the one memory read
// port, one entry per cycle, and one shared multiplier does both products.
// one item at a time; a new item is taken while the last result waits to be taken.
// synchronous active-low reset clears the sequencer, the previous-step record and
// the registers to their defaults; the score memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module q_learning_table_update import qltu_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    qltu_item_if.sink              i_item,
    qltu_result_if.source          o_result,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_W-1:0]        i_cfg_data
);

    // score memory, one read port with registered data, one write port
    logic [SCORE_W-1:0] r_score_mem [0:DEPTH-1];
    logic [SCORE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [SCORE_W-1:0] wr_data;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_learn_rate;
    logic [CFG_W-1:0] r_discount;

    // latched item
    logic                      r_cmd;
    logic [STATE_W-1:0]        r_row;
    logic [ACT_W-1:0]          r_col;
    logic [SCORE_W-1:0]        r_load_value;
    logic [DIST_W-1:0]         r_dist;

    // previous step
    logic [STATE_W-1:0] r_prev_state, n_prev_state;
    logic [ACT_W-1:0]   r_prev_action, n_prev_action;
    logic [DIST_W-1:0]  r_prev_dist, n_prev_dist;
    logic               r_have_prev, n_have_prev;

    // scan
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_rd_live, n_rd_live;
    logic [ACT_W-1:0]          r_rd_col, n_rd_col;
    logic signed [SCORE_W-1:0] r_max, n_max;
    logic [ACT_W-1:0]          r_arg, n_arg;

    // update datapath
    logic signed [SCORE_W-1:0] r_old, n_old;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [TD_W-1:0]    r_td, n_td;
    logic signed [SCORE_W-1:0] r_newv, n_newv;
    logic                      r_good, n_good;
    logic                      r_done, n_done;

    // output register
    logic                      r_out_valid, n_out_valid;
    logic [OUT_ACT_W-1:0]      r_out_act, n_out_act;
    logic signed [SCORE_W-1:0] r_out_best, n_out_best;
    logic signed [SCORE_W-1:0] r_out_upd, n_out_upd;
    logic                      r_out_good, n_out_good;
    logic                      r_out_done, n_out_done;

    logic                       accept;
    logic                       issue;
    logic                       scanning;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [TD_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [SUM_W-1:0]    sum;

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;

    assign o_result.valid           = r_out_valid;
    assign o_result.chosen_action   = r_out_act;
    assign o_result.best_score      = r_out_best;
    assign o_result.updated_score   = r_out_upd;
    assign o_result.reward_positive = r_out_good;
    assign o_result.update_done     = r_out_done;

    assign scanning = (r_state == ST_SCAN_PRE) || (r_state == ST_SCAN_POST);
    assign issue    = scanning && (r_cnt < CNT_W'(ACTIONS));

    // shared multiplier and round-half-up to q16.16
    assign mul_p   = mul_a * mul_b;
    assign rounded = (r_prod + ROUND_HALF) >>> FRAC_W;
    assign sum     = SUM_W'(r_old) + rounded[SUM_W-1:0];

    always_comb begin
        mul_a = $signed({1'b0, r_learn_rate});
        mul_b = r_td;
        if (r_state == ST_OLD) begin
            mul_a = $signed({1'b0, r_discount});
            mul_b = TD_W'(r_max);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_prev_state  = r_prev_state;
        n_prev_action = r_prev_action;
        n_prev_dist   = r_prev_dist;
        n_have_prev   = r_have_prev;
        n_cnt         = r_cnt;
        n_rd_live     = 1'b0;
        n_rd_col      = r_cnt[ACT_W-1:0];
        n_max         = r_max;
        n_arg         = r_arg;
        n_old         = r_old;
        n_prod        = r_prod;
        n_td          = r_td;
        n_newv        = r_newv;
        n_good        = r_good;
        n_done        = r_done;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_act     = r_out_act;
        n_out_best    = r_out_best;
        n_out_upd     = r_out_upd;
        n_out_good    = r_out_good;
        n_out_done    = r_out_done;
        rd_addr       = {r_row, r_cnt[ACT_W-1:0]};
        wr_en         = 1'b0;
        wr_addr       = {r_row, r_col};
        wr_data       = r_load_value;

        // running max over the row, strict compare keeps the lowest index on ties
        if (scanning && r_rd_live) begin
            if (r_rd_col == '0 || $signed(r_rd_data) > r_max) begin
                n_max = $signed(r_rd_data);
                n_arg = r_rd_col;
            end
        end
        if (issue) begin
            n_cnt     = r_cnt + CNT_W'(1);
            n_rd_live = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_newv = '0;
                    n_good = 1'b0;
                    n_done = 1'b0;
                    n_cnt  = '0;
                    if (i_item.cmd == CMD_LOAD) begin
                        n_state = ST_LOAD;
                    end else if (r_have_prev) begin
                        n_state = ST_SCAN_PRE;
                    end else begin
                        n_state = ST_SCAN_POST;
                    end
                end
            end
            ST_LOAD: begin
                wr_en   = 1'b1;
                n_state = ST_OUT;
            end
            ST_SCAN_PRE: begin
                if (r_cnt == CNT_W'(ACTIONS) && r_rd_live) begin
                    n_state = ST_RD_OLD;
                end
            end
            ST_RD_OLD: begin
                rd_addr = {r_prev_state, r_prev_action};
                n_state = ST_OLD;
            end
            ST_OLD: begin
                n_old   = $signed(r_rd_data);
                n_prod  = mul_p;
                n_state = ST_TD;
            end
            ST_TD: begin
                // reward + gamma*max - old
                n_good = (r_dist < r_prev_dist);
                n_td   = (n_good ? REWARD_GOOD : REWARD_BAD) + rounded[TD_W-1:0]
                         - TD_W'(r_old);
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = mul_p;
                n_state = ST_WR;
            end
            ST_WR: begin
                // saturate old + delta to 32 bits
                if (sum[SUM_W-1:SCORE_W-1] == '0 || sum[SUM_W-1:SCORE_W-1] == '1) begin
                    n_newv = sum[SCORE_W-1:0];
                end else if (sum[SUM_W-1]) begin
                    n_newv = {1'b1, {(SCORE_W-1){1'b0}}};
                end else begin
                    n_newv = {1'b0, {(SCORE_W-1){1'b1}}};
                end
                wr_en   = 1'b1;
                wr_addr = {r_prev_state, r_prev_action};
                wr_data = n_newv;
                n_done  = 1'b1;
                n_cnt   = '0;
                n_state = ST_SCAN_POST;
            end
            ST_SCAN_POST: begin
                if (r_cnt == CNT_W'(ACTIONS) && r_rd_live) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    if (r_cmd == CMD_LOAD) begin
                        n_out_act  = '0;
                        n_out_best = '0;
                        n_out_upd  = '0;
                        n_out_good = 1'b0;
                        n_out_done = 1'b0;
                    end else begin
                        n_out_act     = OUT_ACT_W'(r_arg);
                        n_out_best    = r_max;
                        n_out_upd     = r_newv;
                        n_out_good    = r_good;
                        n_out_done    = r_done;
                        n_prev_state  = r_row;
                        n_prev_action = r_arg;
                        n_prev_dist   = r_dist;
                        n_have_prev   = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_score_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_score_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_learn_rate  <= LEARN_RATE_RST;
            r_discount    <= DISCOUNT_RST;
            r_prev_state  <= '0;
            r_prev_action <= '0;
            r_prev_dist   <= '1;
            r_have_prev   <= 1'b0;
            r_rd_live     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_prev_state  <= n_prev_state;
            r_prev_action <= n_prev_action;
            r_prev_dist   <= n_prev_dist;
            r_have_prev   <= n_have_prev;
            r_rd_live     <= n_rd_live;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEARN_RATE: r_learn_rate <= i_cfg_data;
                    CFG_DISCOUNT:   r_discount   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= i_item.cmd;
            r_row        <= i_item.state_index[STATE_W-1:0];
            r_col        <= i_item.action_index[ACT_W-1:0];
            r_load_value <= i_item.load_value;
            r_dist       <= i_item.target_distance;
        end
        r_cnt      <= n_cnt;
        r_rd_col   <= n_rd_col;
        r_max      <= n_max;
        r_arg      <= n_arg;
        r_old      <= n_old;
        r_prod     <= n_prod;
        r_td       <= n_td;
        r_newv     <= n_newv;
        r_good     <= n_good;
        r_done     <= n_done;
        r_out_act  <= n_out_act;
        r_out_best <= n_out_best;
        r_out_upd  <= n_out_upd;
        r_out_good <= n_out_good;
        r_out_done <= n_out_done;
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_q_learning_table_update.sv
// self-checking bench for the q-table update engine: load and step items with random
// pacing, a scoreboard that predicts every result. depends on qltu_pkg, qltu_item_if,
// qltu_result_if and q_learning_table_update
`timescale 1ns / 1ps

import qltu_pkg::*;

localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
localparam longint REWARD_UP   = 65536;
localparam longint REWARD_DOWN = -327680;

typedef struct packed {
    logic                      cmd;
    logic [IN_STATE_W-1:0]     row;
    logic [IN_ACT_W-1:0]       col;
    logic signed [SCORE_W-1:0] score;
    logic [DIST_W-1:0]         tgt_dist;
} t_cmd_item;

typedef struct packed {
    logic [OUT_ACT_W-1:0]      action;
    logic signed [SCORE_W-1:0] best;
    logic signed [SCORE_W-1:0] updated;
    logic                      good;
    logic                      done;
} t_step_result;

class qtable_scoreboard;
    int                scores[DEPTH];
    bit                prev_valid;
    int                prev_row;
    int                prev_act;
    logic [DIST_W-1:0] prev_dist;
    int                learn_q16;
    int                discount_q16;
    t_step_result      expected_q[$];
    int                errors;
    int                results_seen;

    function new();
        prev_valid   = 1'b0;
        prev_row     = 0;
        prev_act     = 0;
        prev_dist    = '1;
        learn_q16    = int'(LEARN_RATE_RST);
        discount_q16 = int'(DISCOUNT_RST);
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        if (idx == CFG_LEARN_RATE) begin
            learn_q16 = int'(val & 32'h1_FFFF);
        end else if (idx == CFG_DISCOUNT) begin
            discount_q16 = int'(val & 32'h1_FFFF);
        end
    endfunction

    // product back to q16.16, round half up
    function longint round_q16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function longint clamp32(longint x);
        if (x > longint'(SCORE_MAX)) return longint'(SCORE_MAX);
        if (x < longint'(SCORE_MIN)) return longint'(SCORE_MIN);
        return x;
    endfunction

    // lowest column wins ties
    function void row_best(input int row, output int pick, output int top);
        top  = scores[row * ACTIONS];
        pick = 0;
        for (int k = 1; k < ACTIONS; k++) begin
            if (scores[row * ACTIONS + k] > top) begin
                top  = scores[row * ACTIONS + k];
                pick = k;
            end
        end
    endfunction

    function void note_input(t_cmd_item it);
        t_step_result r;
        int           row;
        int           idx;
        int           pick;
        int           top;
        int           rowmax;
        longint       old;
        longint       g;
        longint       td;
        longint       nv;
        r   = '0;
        row = int'(it.row) % STATES;
        if (it.cmd == CMD_LOAD) begin
            scores[row * ACTIONS + (int'(it.col) % ACTIONS)] = it.score;
        end else begin
            if (prev_valid) begin
                idx = prev_row * ACTIONS + prev_act;
                old = scores[idx];
                // max of the current row before the previous entry changes
                row_best(row, pick, rowmax);
                r.good = (it.tgt_dist < prev_dist);
                g  = round_q16(longint'(discount_q16) * longint'(rowmax));
                td = (r.good ? REWARD_UP : REWARD_DOWN) + g - old;
                nv = clamp32(old + round_q16(longint'(learn_q16) * td));
                scores[idx] = int'(nv);
                r.updated   = nv[SCORE_W-1:0];
                r.done      = 1'b1;
            end
            row_best(row, pick, top);
            r.action   = pick[OUT_ACT_W-1:0];
            r.best     = top;
            prev_row   = row;
            prev_act   = pick;
            prev_dist  = it.tgt_dist;
            prev_valid = 1'b1;
        end
        expected_q.push_back(r);
    endfunction

    task report(string what);
        errors++;
        if (errors <= 100) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    task check_result(t_step_result got);
        t_step_result want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report($sformatf("result %0d arrived with no item pending", results_seen));
            return;
        end
        want = expected_q.pop_front();
        if (got.action !== want.action)
            report($sformatf("result %0d chosen_action %0d, want %0d",
                results_seen, got.action, want.action));
        if (got.best !== want.best)
            report($sformatf("result %0d best_score %0d, want %0d",
                results_seen, got.best, want.best));
        if (got.updated !== want.updated)
            report($sformatf("result %0d updated_score %0d, want %0d",
                results_seen, got.updated, want.updated));
        if (got.good !== want.good)
            report($sformatf("result %0d reward_positive %b, want %b",
                results_seen, got.good, want.good));
        if (got.done !== want.done)
            report($sformatf("result %0d update_done %b, want %b",
                results_seen, got.done, want.done));
    endtask

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_q_learning_table_update;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 170;

    typedef enum int {
        TAKE_ALL,
        TAKE_HALF,
        TAKE_QUARTER,
        TAKE_PULSED
    } t_take_mode;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    qltu_item_if   item_if ();
    qltu_result_if result_if ();

    q_learning_table_update i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    qtable_scoreboard sb;

    // stimulus bookkeeping: a step only goes to a row whose every entry was loaded
    bit [ACTIONS-1:0]  row_loaded[STATES];
    int                ready_rows[$];
    int                last_row = 0;
    logic [DIST_W-1:0] last_dist = '1;
    int                burst_left = 0;
    bit                offer_on = 1'b0;
    int                items_in = 0;
    int                quiet_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin : watch_items
        t_cmd_item it;
        if (item_if.valid && item_if.ready) begin
            it.cmd      = item_if.cmd;
            it.row      = item_if.state_index;
            it.col      = item_if.action_index;
            it.score    = item_if.load_value;
            it.tgt_dist = item_if.target_distance;
            sb.note_input(it);
            items_in++;
        end
    end

    always @(posedge clk) begin : watch_results
        t_step_result r;
        if (result_if.valid && result_if.ready) begin
            r.action  = result_if.chosen_action;
            r.best    = result_if.best_score;
            r.updated = result_if.updated_score;
            r.good    = result_if.reward_positive;
            r.done    = result_if.update_done;
            sb.check_result(r);
        end
    end

    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // result side pacing; one long hold-off once traffic is flowing so the engine backs up
    initial begin : result_taker
        t_take_mode mode;
        int         seg_left;
        int         hold_left;
        bit         held;
        logic       take;
        mode      = TAKE_ALL;
        seg_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (!held && items_in >= 400) begin
                held      = 1'b1;
                hold_left = 300;
                take      = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_take_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    TAKE_ALL:     take = 1'b1;
                    TAKE_HALF:    take = 1'($urandom_range(0, 1));
                    TAKE_QUARTER: take = ($urandom_range(0, 3) == 0);
                    default:      take = ((seg_left % 8) < 5);
                endcase
            end
            result_if.ready <= take;
        end
    end

    task automatic send_item(input t_cmd_item it);
        item_if.valid           <= 1'b1;
        item_if.cmd             <= it.cmd;
        item_if.state_index     <= it.row;
        item_if.action_index    <= it.col;
        item_if.load_value      <= it.score;
        item_if.target_distance <= it.tgt_dist;
        offer_on = 1'b1;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            item_if.valid <= 1'b0;
            offer_on = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_load(input int row, input int col, input logic signed [SCORE_W-1:0] v);
        t_cmd_item it;
        it.cmd      = CMD_LOAD;
        it.row      = IN_STATE_W'(row);
        it.col      = IN_ACT_W'(col);
        it.score    = v;
        it.tgt_dist = DIST_W'($urandom_range(0, 24'hFF_FFFF));
        if (row_loaded[row] != '1) begin
            row_loaded[row][col] = 1'b1;
            if (row_loaded[row] == '1) ready_rows.push_back(row);
        end
        send_item(it);
    endtask

    task automatic send_step(input int row, input logic [DIST_W-1:0] new_dist);
        t_cmd_item it;
        it.cmd      = CMD_STEP;
        it.row      = IN_STATE_W'(row);
        it.col      = IN_ACT_W'($urandom_range(0, 7));
        it.score    = $urandom;
        it.tgt_dist = new_dist;
        last_row  = row;
        last_dist = new_dist;
        send_item(it);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_tie_score();
        case ($urandom_range(0, 3))
            0:       return SCORE_MIN;
            1:       return SCORE_MAX;
            2:       return 32'sh0001_0000;
            default: return 32'sh0000_0000;
        endcase
    endfunction

    function automatic logic signed [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:             return SCORE_MIN;
            1:             return SCORE_MAX;
            2, 3, 4:       return int'($urandom_range(0, 1310720)) - 655360;
            5, 6:          return pick_tie_score();
            default:       return $urandom;
        endcase
    endfunction

    // mostly small moves around the last distance, so both rewards come up often
    function automatic logic [DIST_W-1:0] pick_distance();
        int unsigned d;
        int unsigned span;
        d    = {8'd0, last_dist};
        span = (d < 1000) ? d : 1000;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: if (span > 0) d = d - $urandom_range(1, span);
            7, 8, 9:             ;
            10, 11, 12, 13:      d = d + $urandom_range(1, 1000);
            14:                  d = 0;
            15:                  d = 24'hFF_FFFF;
            default:             d = $urandom_range(0, 24'hFF_FFFF);
        endcase
        if (d > 24'hFF_FFFF) d = 24'hFF_FFFF;
        return d[DIST_W-1:0];
    endfunction

    task automatic fill_row(input int row);
        bit ties;
        ties = 1'($urandom_range(0, 1));
        for (int c = 0; c < ACTIONS; c++) begin
            send_load(row, c, ties ? pick_tie_score() : pick_score());
        end
    endtask

    task automatic random_traffic(input int count);
        int sent;
        int roll;
        int row;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (ready_rows.size() < 4 || roll < 4) begin
                fill_row($urandom_range(0, STATES - 1));
                sent += ACTIONS;
            end else if (roll < 24) begin
                // stray loads, also into rows that steps use
                send_load($urandom_range(0, STATES - 1), $urandom_range(0, ACTIONS - 1),
                          pick_score());
                sent++;
            end else begin
                row = ($urandom_range(0, 2) == 0) ? last_row
                    : ready_rows[$urandom_range(0, ready_rows.size() - 1)];
                send_step(row, pick_distance());
                sent++;
            end
        end
    endtask

    task automatic settle();
        if (offer_on) begin
            item_if.valid <= 1'b0;
            offer_on = 1'b0;
        end
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(input int unsigned lr, input int unsigned dc);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LEARN_RATE;
        cfg_data <= CFG_W'(lr);
        @(posedge clk);
        cfg_idx  <= CFG_DISCOUNT;
        cfg_data <= CFG_W'(dc);
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_register(CFG_LEARN_RATE, lr);
        sb.set_register(CFG_DISCOUNT, dc);
    endtask

    initial begin
        sb = new();
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= CFG_LEARN_RATE;
        cfg_data                <= '0;
        item_if.valid           <= 1'b0;
        item_if.cmd             <= CMD_LOAD;
        item_if.state_index     <= '0;
        item_if.action_index    <= '0;
        item_if.load_value      <= '0;
        item_if.target_distance <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rates: row 0 with extremes and a tie between two max entries
        send_load(0, 0, SCORE_MIN);
        send_load(0, 1, 32'sh0000_0000);
        send_load(0, 2, SCORE_MAX);
        send_load(0, 3, 32'shFFFF_FFFF);
        send_load(0, 4, 32'sh0000_0001);
        send_load(0, 5, SCORE_MAX);
        send_load(0, 6, 32'sh0001_0000);
        send_load(0, 7, 32'shFFFF_0000);
        send_step(0, 24'hFF_FFFF);   // first step, nothing to update
        send_step(0, 24'h00_0000);   // same row, distance shrank
        send_step(0, 24'h00_0000);   // same row, distance held
        settle();

        // unit rates drive both ends of saturation
        write_registers(65536, 65536);
        for (int c = 0; c < ACTIONS; c++) send_load(2, c, SCORE_MIN);
        send_load(0, 7, SCORE_MAX);
        send_step(2, 24'd100);
        send_step(0, 24'd50);
        send_load(2, 0, SCORE_MIN);
        send_step(2, 24'd100);
        random_traffic(PHASE_ITEMS);

        for (int p = 0; p < 7; p++) begin
            settle();
            if (p == 0) begin
                write_registers(0, 65536);
            end else if (p == 1) begin
                write_registers(65536, 0);
            end else if (p == 2) begin
                write_registers(int'(LEARN_RATE_RST), int'(DISCOUNT_RST));
            end else begin
                write_registers($urandom_range(0, 65536), $urandom_range(0, 65536));
            end
            random_traffic(PHASE_ITEMS);
        end
        settle();

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
design/qltu_pkg.sv
design/qltu_item_if.sv
design/qltu_result_if.sv
design/q_learning_table_update.sv
tb/sv/tb_q_learning_table_update.sv
